// ===== hdl/sawl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_pkg
// types and codes shared by the stop-and-wait link endpoint
// ----------------------------------------------------------------------------
package sawl_pkg;

  typedef enum logic [2:0] {
    CmdNewPkt = 3'd0,
    CmdTick   = 3'd1,
    CmdAck    = 3'd2,
    CmdNack   = 3'd3,
    CmdData   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ActNone = 3'd0,
    ActSend = 3'd1,
    ActAck  = 3'd2,
    ActNack = 3'd3,
    ActDrop = 3'd4
  } action_e;

  localparam int unsigned AddrW = 3;
  localparam logic RegTimeout = 1'b0;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] packet_id;
    logic        bit_error;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] out_packet_id;
    logic [7:0]  retrans_count;
    logic [4:0]  queue_level;
  } out_word_t;

endpackage

// ===== hdl/sawl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawl_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface sawl_in_if;
  import sawl_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sawl_out_if;
  import sawl_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/stop_and_wait_arq_link.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_link
// stop-and-wait arq endpoint with a packet queue and retransmit timer
// ----------------------------------------------------------------------------
// cmd_i carries one command word per handshake: queue a new packet, a timer
// tick, an ack or nack from the far end, or a received data frame. res_o
// returns exactly one result word for every command word, in order.
// The apb port holds timeout_ticks at byte address 0; write it only while
// the link is idle.
// A command word's result is registered and shows in the cycle after it is
// taken. One word per cycle while res_o does not stall. The queue lives in a
// synchronous memory whose registered read always holds the entry at the
// head, with a bypass when the head is written in the same cycle.
// A stalled receiver holds the result register; cmd_i is still taken in the
// cycle where the pending result leaves. Reset empties the queue, drops the
// in-flight packet, disarms the timer and sets timeout_ticks to 1000; it
// needs no clearing pass.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_link #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sawl_in_if.sink                  cmd_i,
  sawl_out_if.source               res_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [sawl_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import sawl_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [15:0] fifo_mem [QueueDepth];
  logic [15:0] head_word_q;

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     inflight_id_q, inflight_id_d;
  logic            inflight_valid_q, inflight_valid_d;
  logic [15:0]     timer_left_q, timer_left_d;
  logic            timer_armed_q, timer_armed_d;
  logic [7:0]      retrans_q, retrans_d;
  logic [15:0]     timeout_q;

  out_word_t out_q, out_d;
  logic      out_valid_q;
  logic      accept;
  logic      wr_en;
  logic      pop;
  logic [15:0] arm_value;
  logic [15:0] timer_dec;
  logic [15:0] head_entry;
  logic [31:0] level_ext;
  action_e     action;

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegTimeout) ? {16'd0, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (psel && penable && pwrite && paddr[AddrW-1] == RegTimeout) begin
      timeout_q <= pwdata[15:0];
    end
  end

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign arm_value   = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
  assign timer_dec   = (timer_left_q != 16'd0) ? timer_left_q - 16'd1 : timer_left_q;
  assign head_entry  = (count_q == '0) ? cmd_i.data.packet_id : head_word_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d           = head_q;
    tail_d           = tail_q;
    count_d          = count_q;
    inflight_id_d    = inflight_id_q;
    inflight_valid_d = inflight_valid_q;
    timer_left_d     = timer_left_q;
    timer_armed_d    = timer_armed_q;
    retrans_d        = retrans_q;
    action           = ActNone;
    wr_en            = 1'b0;
    pop              = 1'b0;

    case (cmd_i.data.command)
      CmdNewPkt: begin
        if (count_q == CntW'(QueueDepth)) begin
          action = ActDrop;
        end else begin
          wr_en  = 1'b1;
          tail_d = next_ptr(tail_q);
          pop    = !inflight_valid_q;
          count_d = pop ? count_q : count_q + 1'b1;
        end
      end
      CmdTick: begin
        if (timer_armed_q) begin
          timer_left_d = timer_dec;
          if (timer_dec == 16'd0) begin
            if (inflight_valid_q) begin
              action       = ActSend;
              timer_left_d = arm_value;
            end else begin
              timer_armed_d = 1'b0;
            end
          end
        end
      end
      CmdAck: begin
        if (inflight_valid_q) begin
          inflight_valid_d = 1'b0;
          timer_armed_d    = 1'b0;
          timer_left_d     = 16'd0;
          if (count_q != '0) begin
            pop     = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
      end
      CmdNack: begin
        if (inflight_valid_q) begin
          if (retrans_q != 8'hff) begin
            retrans_d = retrans_q + 8'd1;
          end
          timer_left_d  = arm_value;
          timer_armed_d = 1'b1;
          action        = ActSend;
        end
      end
      CmdData: begin
        action = cmd_i.data.bit_error ? ActNack : ActAck;
      end
      default: begin
        action = ActNone;
      end
    endcase

    if (pop) begin
      inflight_id_d    = head_entry;
      head_d           = next_ptr(head_q);
      inflight_valid_d = 1'b1;
      retrans_d        = 8'd0;
      timer_left_d     = arm_value;
      timer_armed_d    = 1'b1;
      action           = ActSend;
    end

    level_ext = 32'(count_d);
    out_d.action        = action;
    out_d.out_packet_id = (action == ActSend) ? inflight_id_d : 16'd0;
    out_d.retrans_count = retrans_d;
    out_d.queue_level   = level_ext[4:0];
  end

  // queue storage, registered read of the next head with write bypass
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      fifo_mem[tail_q] <= cmd_i.data.packet_id;
    end
    if (accept && wr_en && tail_q == head_d) begin
      head_word_q <= cmd_i.data.packet_id;
    end else if (accept) begin
      head_word_q <= fifo_mem[head_d];
    end else begin
      head_word_q <= fifo_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q           <= '0;
      tail_q           <= '0;
      count_q          <= '0;
      inflight_id_q    <= 16'd0;
      inflight_valid_q <= 1'b0;
      timer_left_q     <= 16'd0;
      timer_armed_q    <= 1'b0;
      retrans_q        <= 8'd0;
      out_valid_q      <= 1'b0;
    end else begin
      if (accept) begin
        head_q           <= head_d;
        tail_q           <= tail_d;
        count_q          <= count_d;
        inflight_id_q    <= inflight_id_d;
        inflight_valid_q <= inflight_valid_d;
        timer_left_q     <= timer_left_d;
        timer_armed_q    <= timer_armed_d;
        retrans_q        <= retrans_d;
        out_valid_q      <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule

// ===== dv/tb_stop_and_wait_arq_link.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq_link
// self-checking testbench for the stop-and-wait arq link endpoint
// ----------------------------------------------------------------------------
// Drives command words into cmd_i with random gaps and stalls res_o at
// random. Every accepted command word is run through a local model of the
// link (packet queue, in-flight packet, retransmit timer and retransmit
// counter), and each result word is compared field by field with the oldest
// prediction. Directed tests cover the idle link, zero timeout, timer expiry,
// nack, ack on an empty queue, a full queue and counter saturation. Random
// traffic then runs under several timeout settings, written over apb and
// read back while the link is idle.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_arq_link;
  import sawl_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [AddrW-1:0] TimeoutAddr = AddrW'(4 * RegTimeout);

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  sawl_in_if  cmd_if ();
  sawl_out_if res_if ();

  stop_and_wait_arq_link #(
    .QueueDepth(Depth)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // link model state
  logic [15:0] pkt_store [Depth];
  int unsigned q_head = 0;
  int unsigned q_tail = 0;
  int unsigned q_count = 0;
  logic [15:0] busy_id = '0;
  bit          link_busy = 1'b0;
  logic [15:0] retx_left = '0;
  bit          retx_armed = 1'b0;
  logic [7:0]  retx_count = '0;
  logic [15:0] timeout_cfg = TimeoutReset;

  out_word_t result_q[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int sends_seen = 0;
  int drops_seen = 0;
  int settings_used = 0;
  logic [7:0] retx_peak = '0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int stall_left = 0;

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void arm_retx_timer();
    retx_left  = (timeout_cfg == '0) ? 16'd1 : timeout_cfg;
    retx_armed = 1'b1;
  endfunction

  function automatic bit launch_next();
    if (link_busy || q_count == 0) return 1'b0;
    busy_id    = pkt_store[q_head];
    q_head     = (q_head + 1) % Depth;
    q_count--;
    link_busy  = 1'b1;
    retx_count = '0;
    arm_retx_timer();
    return 1'b1;
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    action_e   act;
    out_word_t r;
    act = ActNone;
    case (w.command)
      CmdNewPkt: begin
        if (q_count >= Depth) begin
          act = ActDrop;
        end else begin
          pkt_store[q_tail] = w.packet_id;
          q_tail = (q_tail + 1) % Depth;
          q_count++;
          if (launch_next()) act = ActSend;
        end
      end
      CmdTick: begin
        if (retx_armed) begin
          if (retx_left > 0) retx_left--;
          if (retx_left == 0) begin
            if (link_busy) begin
              act = ActSend;
              arm_retx_timer();
            end else begin
              retx_armed = 1'b0;
            end
          end
        end
      end
      CmdAck: begin
        if (link_busy) begin
          link_busy  = 1'b0;
          retx_armed = 1'b0;
          retx_left  = '0;
          if (launch_next()) act = ActSend;
        end
      end
      CmdNack: begin
        if (link_busy) begin
          if (retx_count != 8'hFF) retx_count++;
          arm_retx_timer();
          act = ActSend;
        end
      end
      CmdData: begin
        act = w.bit_error ? ActNack : ActAck;
      end
      default: begin
      end
    endcase
    r.action        = act;
    r.out_packet_id = (act == ActSend) ? busy_id : '0;
    r.retrans_count = retx_count;
    r.queue_level   = 5'(q_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // predict on command words, check result words
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) result_q.push_back(predict_result(cmd_if.data));
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        results_seen++;
        if (got.action == ActSend) sends_seen++;
        if (got.action == ActDrop) drops_seen++;
        if (got.retrans_count > retx_peak) retx_peak = got.retrans_count;
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", got));
        end else begin
          want = result_q.pop_front();
          if (got.action !== want.action)
            report_mismatch($sformatf("action %0d, expected %0d", got.action, want.action));
          if (got.out_packet_id !== want.out_packet_id)
            report_mismatch($sformatf("out_packet_id %h, expected %h",
                                      got.out_packet_id, want.out_packet_id));
          if (got.retrans_count !== want.retrans_count)
            report_mismatch($sformatf("retrans_count %0d, expected %0d",
                                      got.retrans_count, want.retrans_count));
          if (got.queue_level !== want.queue_level)
            report_mismatch($sformatf("queue_level %0d, expected %0d",
                                      got.queue_level, want.queue_level));
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
      if (!recv_quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap(1'b0);
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [15:0] id, logic berr);
    int gap;
    in_word_t w;
    gap = pick_gap(send_quiet);
    w.command   = cmd;
    w.packet_id = id;
    w.bit_error = berr;
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_read(output logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TimeoutAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeout(logic [15:0] ticks);
    logic [31:0] rd;
    wait_all_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TimeoutAddr;
    pwdata  <= {16'd0, ticks};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    timeout_cfg = ticks;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apb_read(rd);
    if (rd[15:0] !== ticks)
      report_mismatch($sformatf("timeout_ticks read %0d, expected %0d", rd[15:0], ticks));
    settings_used++;
  endtask

  // ignored commands on an idle link, data frame answers, reset value
  task automatic test_idle_link();
    logic [31:0] rd;
    apb_read(rd);
    if (rd[15:0] !== TimeoutReset)
      report_mismatch($sformatf("timeout_ticks after reset %0d", rd[15:0]));
    send_word(CmdTick, 16'hFFFF, 1'b1);
    send_word(CmdAck, 16'h0000, 1'b0);
    send_word(CmdNack, 16'hA5A5, 1'b1);
    send_word(3'(CmdData) + 3'd3, 16'h5A5A, 1'b1);
    send_word(CmdData, 16'h0000, 1'b0);
    send_word(CmdData, 16'hFFFF, 1'b1);
    wait_all_results();
  endtask

  // zero timeout, expiry resend, nack, ack on an empty queue, fresh send
  task automatic test_single_packet();
    set_timeout(16'd0);
    send_word(CmdNewPkt, 16'hFFFF, 1'b0);
    send_word(CmdTick, 16'h1234, 1'b0);
    send_word(CmdNack, 16'h0000, 1'b0);
    send_word(CmdAck, 16'h0000, 1'b0);
    send_word(CmdNewPkt, 16'h0000, 1'b1);
    wait_all_results();
  endtask

  task automatic test_queue_full();
    set_timeout(16'hFFFF);
    repeat (Depth + 1) send_word(CmdNewPkt, 16'($urandom), 1'($urandom));
    wait_all_results();
  endtask

  task automatic test_retrans_saturation();
    repeat (260) send_word(CmdNack, 16'($urandom), 1'($urandom));
    repeat (Depth + 1) send_word(CmdAck, 16'($urandom), 1'($urandom));
    wait_all_results();
  endtask

  task automatic test_random_traffic(int n_words, logic [15:0] ticks, bit quiet);
    int done;
    int pick;
    logic [2:0] cmd;
    set_timeout(ticks);
    send_quiet = quiet;
    recv_quiet = quiet;
    done = 0;
    while (done < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // burst that overruns the queue
        repeat (Depth + 2) send_word(CmdNewPkt, 16'($urandom), 1'($urandom));
        done += Depth + 2;
      end else if (pick < 5) begin
        wait_all_results();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) cmd = CmdNewPkt;
        else if (pick < 60) cmd = CmdTick;
        else if (pick < 75) cmd = CmdAck;
        else if (pick < 85) cmd = CmdNack;
        else if (pick < 97) cmd = CmdData;
        else cmd = 3'(CmdData) + 3'($urandom_range(1, 3));
        send_word(cmd, 16'($urandom), 1'($urandom));
        done++;
      end
    end
    wait_all_results();
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    res_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_link();
    test_single_packet();
    test_queue_full();
    test_retrans_saturation();
    test_random_traffic(170, 16'd1, 1'b0);
    test_random_traffic(170, 16'd3, 1'b1);
    test_random_traffic(170, 16'($urandom_range(2, 12)), 1'b0);
    test_random_traffic(170, 16'hFFFF, 1'b0);
    test_random_traffic(170, 16'd0, 1'b0);

    wait_all_results();
    repeat (5) @(posedge clk_i);
    if (result_q.size() != 0) report_mismatch("results still expected at end of run");
    $display("covered %0d command words under %0d timeout settings",
             words_sent, settings_used);
    $display("checked %0d results: %0d sends, %0d drops, retransmit count peak %0d",
             results_seen, sends_seen, drops_seen, retx_peak);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", result_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== stop_and_wait_arq_link.f =====
hdl/sawl_pkg.sv
hdl/sawl_if.sv
hdl/stop_and_wait_arq_link.sv
dv/tb_stop_and_wait_arq_link.sv
